FILE: src/b64e_pkg.sv
// Package for the Base64 byte encoder: payload types, job type, constants, alphabet lookup.
`default_nettype none
package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } t_out_item;

    typedef logic [6:0] t_char;

    // One accepted byte turned into up to four characters.
    typedef struct packed {
        t_char [3:0] chars;     // chars[0] goes out first
        logic  [1:0] last_idx;  // index of the final character of this job
        logic        eom;       // mark the final character as end of message
    } t_job;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam t_char PAD_CHAR = 7'h3D;   // '='
    localparam t_char CHR_UC_A = 7'h41;   // 'A'
    localparam t_char CHR_LC_A = 7'h61;   // 'a'
    localparam t_char CHR_ZERO = 7'h30;   // '0'
    localparam t_char CHR_PLUS = 7'h2B;   // '+'
    localparam t_char CHR_SLSH = 7'h2F;   // '/'

    localparam logic [5:0] SEXT_LC_BASE  = 6'd26;
    localparam logic [5:0] SEXT_DIG_BASE = 6'd52;
    localparam logic [5:0] SEXT_PLUS     = 6'd62;

    // Standard Base64 alphabet lookup.
    function automatic t_char sextet_to_char(input logic [5:0] s);
        t_char c;
        if (s < SEXT_LC_BASE) begin
            c = CHR_UC_A + {1'b0, s};
        end else if (s < SEXT_DIG_BASE) begin
            c = CHR_LC_A + {1'b0, s - SEXT_LC_BASE};
        end else if (s < SEXT_PLUS) begin
            c = CHR_ZERO + {1'b0, s - SEXT_DIG_BASE};
        end else if (s == SEXT_PLUS) begin
            c = CHR_PLUS;
        end else begin
            c = CHR_SLSH;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/b64e_front.sv
// Front end: takes raw bytes, tracks the group position and builds character jobs.
`default_nettype none
module b64e_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  b64e_pkg::t_in_item   i_data,
    input  wire                  i_room,
    output logic                 o_ready,
    output logic                 o_push,
    output b64e_pkg::t_job       o_job
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [7:0] b;
    logic       eom;

    assign b       = i_data.data_byte;
    assign eom     = i_data.end_of_message;
    assign o_ready = i_room;
    assign o_push  = i_valid && i_room;

    always_comb begin
        o_job.chars    = {4{b64e_pkg::PAD_CHAR}};
        o_job.last_idx = 2'd0;
        o_job.eom      = eom;
        n_phase        = b64e_pkg::PHASE_FIRST;
        n_carry        = 4'd0;
        case (r_phase)
            b64e_pkg::PHASE_SECOND: begin
                o_job.chars[0] = b64e_pkg::sextet_to_char({r_carry[1:0], b[7:4]});
                if (eom) begin
                    o_job.chars[1] = b64e_pkg::sextet_to_char({b[3:0], 2'b00});
                    o_job.last_idx = 2'd2;
                end else begin
                    n_carry = b[3:0];
                    n_phase = b64e_pkg::PHASE_THIRD;
                end
            end
            b64e_pkg::PHASE_THIRD: begin
                o_job.chars[0] = b64e_pkg::sextet_to_char({r_carry, b[7:6]});
                o_job.chars[1] = b64e_pkg::sextet_to_char(b[5:0]);
                o_job.last_idx = 2'd1;
            end
            default: begin
                // first byte of a group; the unused phase code acts the same
                o_job.chars[0] = b64e_pkg::sextet_to_char(b[7:2]);
                if (eom) begin
                    o_job.chars[1] = b64e_pkg::sextet_to_char({b[1:0], 4'b0000});
                    o_job.last_idx = 2'd3;
                end else begin
                    n_carry = {2'b00, b[1:0]};
                    n_phase = b64e_pkg::PHASE_SECOND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PHASE_FIRST;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule
`default_nettype wire

FILE: src/b64e_queue.sv
// Two-entry job queue between the front end and the character serialiser.
`default_nettype none
module b64e_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  b64e_pkg::t_job   i_job,
    output logic             o_room,
    input  wire              i_pop,
    output logic             o_valid,
    output b64e_pkg::t_job   o_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    b64e_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_room  = (r_count != (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/b64e_back.sv
// Back end: feeds job characters to an output register, one per cycle while not stalled.
`default_nettype none
module b64e_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    input  b64e_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output b64e_pkg::t_out_item  o_data
);

    logic [1:0]           r_idx;
    logic                 r_valid;
    b64e_pkg::t_out_item  r_data;
    logic                 load, at_end;

    assign load    = i_job_valid && (!r_valid || i_ready);
    assign at_end  = (r_idx == i_job.last_idx);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_char <= i_job.chars[r_idx];
            r_data.out_last <= i_job.eom && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/base64_byte_encoder.sv
// Top level of the Base64 byte encoder: front end, job queue and character serialiser.
//
// Usage: raw bytes enter on the input channel (i_valid / o_ready, payload i_data),
// one byte per item, with end_of_message set on the final byte of a message.
// Base64 characters leave on the output channel (o_valid / i_ready, payload o_data),
// one character per item; out_last marks the final character, padding included.
// A byte gives one character at the start or middle of a group, two at the end of
// a group, and three or four (with '=' padding) when it closes a partial group.
// Path: the first character of a byte is written into the job queue, then loaded into
// the output register, which drives o_valid.
// Throughput: while the receiver is ready the output register sends one character per cycle;
// a byte gives 1 to 4 characters, about 1.33 on a long message. The two-entry job queue
// lets the front take a byte every cycle while it has room.
// When the receiver stalls the output register holds its item, the queue fills and
// o_ready falls; nothing is lost. Synchronous reset empties the queue, drops any
// pending output and returns to the start of a three-byte group.
`default_nettype none
module base64_byte_encoder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  b64e_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output b64e_pkg::t_out_item  o_data
);

    logic           q_room, q_push, q_pop, q_valid;
    b64e_pkg::t_job front_job, head_job;

    // classify the byte and build its characters
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_room  (q_room),
        .o_ready (o_ready),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    // decouples byte intake from character output
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_room  (q_room),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // one character per cycle into the output register while the receiver is ready
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire
